>>> rtl/awm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types and constants for the acknowledgement wait/retry matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

    localparam int HASH_W   = 24;
    localparam int ADDR_W   = 8;
    localparam int FLAGS_W  = 8;
    localparam int STATUS_W = 8;
    localparam int TICKS_W  = 16;
    localparam int WIN_W    = 8;

    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICKS_W-1:0]  RESET_WINDOW_TICKS = 16'd250;
    localparam logic [WIN_W-1:0]    RESET_MAX_WINDOWS  = 8'd10;
    localparam logic [FLAGS_W-1:0]  RESET_SUCCESS_CODE = 8'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED    = 8'hFF;

    localparam logic OUTCOME_DELIVERED = 1'b0;
    localparam logic OUTCOME_FAILED    = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_FRAME = 2'd2
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_TICKS = 2'd0,
        REG_MAX_WINDOWS  = 2'd1,
        REG_SUCCESS_CODE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [TICKS_W-1:0] window_ticks;
        logic [WIN_W-1:0]   max_windows;
        logic [FLAGS_W-1:0] success_flags_code;
    } cfg_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [HASH_W-1:0]   sent_hash;
        logic [ADDR_W-1:0]   sent_src;
        logic [ADDR_W-1:0]   sent_dst;
        logic [ADDR_W-1:0]   rx_dst;
        logic [ADDR_W-1:0]   rx_src;
        logic [FLAGS_W-1:0]  rx_flags;
        logic [HASH_W-1:0]   rx_hash;
        logic [STATUS_W-1:0] rx_status;
    } item_t;

    typedef struct packed {
        logic             outcome;
        logic [WIN_W-1:0] windows_used;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/awm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_cfg_regs
// Configuration register file: window length, window count, success flags.
// ----------------------------------------------------------------------------
module awm_cfg_regs
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [awm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [awm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output awm_pkg::cfg_t                    cfg
);

    awm_pkg::cfg_t cfg_reg;
    awm_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (awm_pkg::reg_idx_t'(cfg_addr))
                awm_pkg::REG_WINDOW_TICKS:
                    cfg_next.window_ticks = cfg_data[awm_pkg::TICKS_W-1:0];
                awm_pkg::REG_MAX_WINDOWS:
                    cfg_next.max_windows = cfg_data[awm_pkg::WIN_W-1:0];
                awm_pkg::REG_SUCCESS_CODE:
                    cfg_next.success_flags_code = cfg_data[awm_pkg::FLAGS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ticks       <= awm_pkg::RESET_WINDOW_TICKS;
            cfg_reg.max_windows        <= awm_pkg::RESET_MAX_WINDOWS;
            cfg_reg.success_flags_code <= awm_pkg::RESET_SUCCESS_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/awm_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_in_stage
// Input register: unpacks a slave beat and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module awm_in_stage
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [awm_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire  [awm_pkg::CMD_W-1:0]        s_tuser,
    output logic                             item_valid,
    output awm_pkg::item_t                   item,
    input  wire                              item_pop
);

    logic           valid_reg;
    logic           valid_next;
    awm_pkg::item_t item_reg;
    awm_pkg::item_t item_next;
    logic           load;

    // take a new beat when empty or when the held one leaves this cycle
    assign s_tready   = !valid_reg || item_pop;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_pop)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end

        item_next           = item_reg;
        if (load)
        begin
            item_next.cmd       = awm_pkg::cmd_t'(s_tuser);
            item_next.sent_hash = s_tdata[23:0];
            item_next.sent_src  = s_tdata[31:24];
            item_next.sent_dst  = s_tdata[39:32];
            item_next.rx_dst    = s_tdata[47:40];
            item_next.rx_src    = s_tdata[55:48];
            item_next.rx_flags  = s_tdata[63:56];
            item_next.rx_hash   = s_tdata[87:64];
            item_next.rx_status = s_tdata[95:88];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule
`default_nettype wire

>>> rtl/awm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awm_engine
// Wait state, tick/window counters, ack compare and the result register.
// ----------------------------------------------------------------------------
module awm_engine
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  awm_pkg::cfg_t         cfg,
    input  wire                   item_valid,
    input  awm_pkg::item_t        item,
    output logic                  item_pop,
    output logic                  res_valid,
    input  wire                   res_ready,
    output awm_pkg::result_t      res
);

    logic                         waiting_reg;
    logic                         waiting_next;
    logic [awm_pkg::HASH_W-1:0]   exp_hash_reg;
    logic [awm_pkg::HASH_W-1:0]   exp_hash_next;
    logic [awm_pkg::ADDR_W-1:0]   exp_src_reg;
    logic [awm_pkg::ADDR_W-1:0]   exp_src_next;
    logic [awm_pkg::ADDR_W-1:0]   exp_dst_reg;
    logic [awm_pkg::ADDR_W-1:0]   exp_dst_next;
    logic [awm_pkg::WIN_W-1:0]    win_idx_reg;
    logic [awm_pkg::WIN_W-1:0]    win_idx_next;
    logic [awm_pkg::TICKS_W-1:0]  tick_reg;
    logic [awm_pkg::TICKS_W-1:0]  tick_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    awm_pkg::result_t             out_reg;
    awm_pkg::result_t             out_next;

    logic                         advance;
    logic [awm_pkg::TICKS_W:0]    tick_inc;
    logic                         tick_expired;
    logic [awm_pkg::WIN_W-1:0]    win_inc;
    logic                         give_up;
    logic                         ack_match;
    logic                         res_load;

    // a held result blocks the engine for every item kind, though only tick and frame items can produce one
    assign advance  = item_valid && (!out_valid_reg || res_ready);
    assign item_pop = advance;

    assign tick_inc     = {1'b0, tick_reg} + {{awm_pkg::TICKS_W{1'b0}}, 1'b1};
    assign tick_expired = tick_inc >= {1'b0, cfg.window_ticks};
    assign win_inc      = win_idx_reg + {{(awm_pkg::WIN_W-1){1'b0}}, 1'b1};
    assign give_up      = win_inc >= cfg.max_windows;

    // ack: same check value, addresses swapped, success flags, status accepted
    assign ack_match = (item.rx_hash == exp_hash_reg)
                    && (item.rx_dst == exp_src_reg)
                    && (item.rx_src == exp_dst_reg)
                    && (item.rx_flags == cfg.success_flags_code)
                    && (item.rx_status == awm_pkg::STATUS_ACCEPTED);

    always_comb
    begin
        waiting_next  = waiting_reg;
        exp_hash_next = exp_hash_reg;
        exp_src_next  = exp_src_reg;
        exp_dst_next  = exp_dst_reg;
        win_idx_next  = win_idx_reg;
        tick_next     = tick_reg;
        res_load      = 1'b0;
        out_next      = out_reg;

        if (advance)
        begin
            case (item.cmd)
                awm_pkg::CMD_START:
                begin
                    exp_hash_next = item.sent_hash;
                    exp_src_next  = item.sent_src;
                    exp_dst_next  = item.sent_dst;
                    win_idx_next  = '0;
                    tick_next     = '0;
                    waiting_next  = 1'b1;
                end
                awm_pkg::CMD_TICK:
                begin
                    if (waiting_reg)
                    begin
                        if (tick_expired)
                        begin
                            tick_next    = '0;
                            win_idx_next = win_inc;
                            if (give_up)
                            begin
                                res_load              = 1'b1;
                                out_next.outcome      = awm_pkg::OUTCOME_FAILED;
                                out_next.windows_used = win_inc;
                                waiting_next          = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc[awm_pkg::TICKS_W-1:0];
                        end
                    end
                end
                awm_pkg::CMD_FRAME:
                begin
                    if (waiting_reg)
                    begin
                        if (ack_match)
                        begin
                            res_load              = 1'b1;
                            out_next.outcome      = awm_pkg::OUTCOME_DELIVERED;
                            out_next.windows_used = win_idx_reg;
                            waiting_next          = 1'b0;
                        end
                        else
                        begin
                            // any other frame closes the window early
                            tick_next    = '0;
                            win_idx_next = win_inc;
                            if (give_up)
                            begin
                                res_load              = 1'b1;
                                out_next.outcome      = awm_pkg::OUTCOME_FAILED;
                                out_next.windows_used = win_inc;
                                waiting_next          = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    waiting_next = waiting_reg;
                end
            endcase
        end

        out_valid_next = out_valid_reg && !res_ready;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg   <= 1'b0;
            exp_hash_reg  <= '0;
            exp_src_reg   <= '0;
            exp_dst_reg   <= '0;
            win_idx_reg   <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            waiting_reg   <= waiting_next;
            exp_hash_reg  <= exp_hash_next;
            exp_src_reg   <= exp_src_next;
            exp_dst_reg   <= exp_dst_next;
            win_idx_reg   <= win_idx_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_result_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> waiting_reg)
        else $error("result produced while not waiting");

    a_result_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> !waiting_reg && out_valid_reg)
        else $error("wait not closed after result");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.cmd == awm_pkg::CMD_START)
        |=> waiting_reg && win_idx_reg == '0 && tick_reg == '0)
        else $error("start did not arm counters");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |-> !item_pop)
        else $error("engine advanced over a held result");

endmodule
`default_nettype wire

>>> rtl/ack_wait_retry_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ack_wait_retry_matcher_core
// Stop-and-wait acknowledgement matcher with per-window timeout and retries.
//
//   channel   direction  handshake           payload
//   s_axis    in         s_tvalid/s_tready   tdata 96b, tuser = cmd
//   m_axis    out        m_tvalid/m_tready   tdata 16b (outcome, windows_used)
//   cfg       in         cfg_valid/cfg_ready cfg_addr = register, cfg_data
//
// One beat accepted per cycle while no result waits on m_axis; a result passes
// through the input register, then the result register.
// The engine stalls only while a result sits unaccepted on m_axis.
// cfg_ready is always high; writes take effect on the next cycle.
// Reset clears the wait state, counters and all valid flags.
// ----------------------------------------------------------------------------
module ack_wait_retry_matcher_core
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [23:0] sent_hash, [31:24] sent_src, [39:32] sent_dst, [47:40] rx_dst,
    // [55:48] rx_src, [63:56] rx_flags, [87:64] rx_hash, [95:88] rx_status
    input  wire  [awm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] cmd
    input  wire  [awm_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [0] outcome, [8:1] windows_used, [15:9] zero
    output logic [awm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [awm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [awm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    awm_pkg::cfg_t    cfg;
    awm_pkg::item_t   item;
    awm_pkg::result_t res;
    logic             item_valid;
    logic             item_pop;

    awm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    awm_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    awm_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {{(awm_pkg::OUT_DATA_W - awm_pkg::WIN_W - 1){1'b0}},
                      res.windows_used, res.outcome};

endmodule
`default_nettype wire
